// File: src/hsp_pkg.sv
// types, constants and the coil table for the half-step positioner
package hsp_pkg;

  localparam int unsigned StepW   = 12;
  localparam int unsigned LapW    = 16;
  localparam int unsigned CountW  = 16;
  localparam int unsigned DelayW  = 16;
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned CoilW   = 4;

  localparam logic [StepW-1:0]  LastStep   = StepW'(4095);
  localparam logic [CountW-1:0] ChunkSteps = CountW'(64);
  localparam logic [DelayW-1:0] MinDelay   = DelayW'(800);
  localparam logic [DelayW-1:0] ResetDelay = DelayW'(800);

  localparam logic [1:0] ReqTick = 2'd0;
  localparam logic [1:0] ReqTurn = 2'd1;
  localparam logic [1:0] ReqGoto = 2'd2;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_TURN = 2'd1,
    MODE_GOTO = 2'd2
  } mode_e;

  typedef struct packed {
    logic [PhaseW-1:0]      phase;
    logic [StepW-1:0]       pos_step;
    logic signed [LapW-1:0] pos_lap;
    logic [CoilW-1:0]       coil;
    logic [DelayW-1:0]      hold;
    logic [CountW-1:0]      remaining;
    logic                   dir;
    mode_e                  mode;
    logic signed [LapW-1:0] goal_lap;
    logic [StepW-1:0]       goal_step;
  } pos_state_t;

  // coils off, position zero, idle, clockwise
  localparam pos_state_t ResetState = '{
    phase:     '0,
    pos_step:  '0,
    pos_lap:   '0,
    coil:      '0,
    hold:      '0,
    remaining: '0,
    dir:       1'b1,
    mode:      MODE_IDLE,
    goal_lap:  '0,
    goal_step: '0
  };

  typedef struct packed {
    logic [1:0]             req;
    logic [CountW-1:0]      move_count;
    logic                   clockwise;
    logic signed [LapW-1:0] target_lap;
    logic [StepW-1:0]       target_step;
  } req_word_t;

  typedef struct packed {
    logic rejected;
    logic speed_err;
  } flags_t;

  function automatic logic [CoilW-1:0] coil_of(input logic [PhaseW-1:0] ph);
    logic [CoilW-1:0] c;
    case (ph)
      3'd0:    c = 4'd9;
      3'd1:    c = 4'd1;
      3'd2:    c = 4'd3;
      3'd3:    c = 4'd2;
      3'd4:    c = 4'd6;
      3'd5:    c = 4'd4;
      3'd6:    c = 4'd12;
      3'd7:    c = 4'd8;
      default: c = 4'd0;
    endcase
    return c;
  endfunction

endpackage

// File: src/stepper_half_step_positioner.sv
// top level of the half-step stepper positioner
//
// input words arrive on the s_axis channel: tuser carries the request kind
// (tick of one microsecond, relative turn, go-to), tdata the command fields.
// every accepted word yields exactly one result word on m_axis giving the
// coil levels, the position (step in lap and signed lap), the moving flag,
// the rejected flag for a command dropped while busy, and the speed error.
// step_delay_i is written whenever step_delay_we_i is high at a clock edge,
// and should only change while the block is idle.
// the result of a word is registered into out_data_q as the word is accepted.
// throughput: one word per cycle unless m_axis stalls; the whole update of
// position, phase and hold count is one next-state logic pass into state_q.
// a single output register holds the result; s_axis_tready_o stays high while
// it is empty or being read, so a stalled receiver stalls the input after
// one word and no result is lost.
// reset: coils off, position zero, idle, direction clockwise, delay 800.
module stepper_half_step_positioner import hsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_delay_we_i,
  input  logic [15:0] step_delay_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // move_count[15:0], clockwise[16], target_lap[32:17], target_step[44:33]
  input  logic [47:0] s_axis_tdata_i,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // coil_drive[3:0], step_in_lap[15:4], lap_count[31:16], moving[32],
  // command_rejected[33], speed_error[34]
  output logic [39:0] m_axis_tdata_o
);

  logic [DelayW-1:0] delay_q;
  pos_state_t        state_q, state_d;
  req_word_t         word;
  flags_t            flags;
  logic              out_valid_q;
  logic [39:0]       out_data_q, out_data_d;
  logic              accept;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign word.req         = s_axis_tuser_i;
  assign word.move_count  = s_axis_tdata_i[15:0];
  assign word.clockwise   = s_axis_tdata_i[16];
  assign word.target_lap  = s_axis_tdata_i[32:17];
  assign word.target_step = s_axis_tdata_i[44:33];

  hsp_step u_step (
    .cur_i   (state_q),
    .word_i  (word),
    .delay_i (delay_q),
    .nxt_o   (state_d),
    .flags_o (flags)
  );

  assign out_data_d = {5'd0, flags.speed_err, flags.rejected,
                       (state_d.mode != MODE_IDLE), state_d.pos_lap,
                       state_d.pos_step, state_d.coil};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= ResetDelay;
    end else if (step_delay_we_i) begin
      delay_q <= step_delay_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ResetState;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// File: src/hsp_step.sv
// next-state logic for one word: tick, turn or go-to
module hsp_step import hsp_pkg::*; (
  input  pos_state_t        cur_i,
  input  req_word_t         word_i,
  input  logic [DelayW-1:0] delay_i,
  output pos_state_t        nxt_o,
  output flags_t            flags_o
);

  typedef struct packed {
    logic              go;
    logic [CountW-1:0] remaining;
    logic              dir;
  } plan_t;

  function automatic plan_t plan(input logic [StepW-1:0] ps, input logic signed [LapW-1:0] pl,
                                 input logic [StepW-1:0] gs, input logic signed [LapW-1:0] gl);
    plan_t p;
    p.go = 1'b1;
    p.remaining = '0;
    p.dir = 1'b1;
    if (pl == gl) begin
      if (ps == gs) begin
        p.go = 1'b0;
      end else if (ps > gs) begin
        p.remaining = CountW'(ps - gs);
        p.dir = 1'b0;
      end else begin
        p.remaining = CountW'(gs - ps);
        p.dir = 1'b1;
      end
    end else begin
      p.remaining = ChunkSteps;
      p.dir = (pl < gl);
    end
    return p;
  endfunction

  logic              speed_err;
  logic [StepW-1:0]  tstep;
  plan_t             cmd_plan;
  plan_t             end_plan;
  logic [DelayW-1:0] hold_inc;
  logic [PhaseW-1:0] adv_phase;
  logic [StepW-1:0]  adv_step;
  logic signed [LapW-1:0] adv_lap;
  logic [CountW-1:0] rem_dec;

  assign speed_err = delay_i < MinDelay;
  assign tstep     = (word_i.target_step > LastStep) ? LastStep : word_i.target_step;
  assign cmd_plan  = plan(cur_i.pos_step, cur_i.pos_lap, tstep, word_i.target_lap);
  assign hold_inc  = cur_i.hold + DelayW'(1);
  assign rem_dec   = cur_i.remaining - CountW'(1);

  always_comb begin
    if (cur_i.dir) begin
      adv_phase = cur_i.phase + PhaseW'(1);
      if (cur_i.pos_step >= LastStep) begin
        adv_step = '0;
        adv_lap  = cur_i.pos_lap + LapW'(1);
      end else begin
        adv_step = cur_i.pos_step + StepW'(1);
        adv_lap  = cur_i.pos_lap;
      end
    end else begin
      adv_phase = cur_i.phase - PhaseW'(1);
      if (cur_i.pos_step == '0) begin
        adv_step = LastStep;
        adv_lap  = cur_i.pos_lap - LapW'(1);
      end else begin
        adv_step = cur_i.pos_step - StepW'(1);
        adv_lap  = cur_i.pos_lap;
      end
    end
  end

  assign end_plan = plan(adv_step, adv_lap, cur_i.goal_step, cur_i.goal_lap);

  always_comb begin
    nxt_o = cur_i;
    flags_o.rejected  = 1'b0;
    flags_o.speed_err = speed_err;
    if (word_i.req == ReqTurn || word_i.req == ReqGoto) begin
      if (cur_i.mode != MODE_IDLE) begin
        flags_o.rejected = 1'b1;
      end else if (!speed_err) begin
        if (word_i.req == ReqTurn) begin
          if (word_i.move_count != '0) begin
            nxt_o.remaining = word_i.move_count;
            nxt_o.dir       = word_i.clockwise;
            nxt_o.mode      = MODE_TURN;
            nxt_o.coil      = coil_of(cur_i.phase);
            nxt_o.hold      = '0;
          end
        end else begin
          nxt_o.goal_lap  = word_i.target_lap;
          nxt_o.goal_step = tstep;
          if (cmd_plan.go) begin
            nxt_o.remaining = cmd_plan.remaining;
            nxt_o.dir       = cmd_plan.dir;
            nxt_o.mode      = MODE_GOTO;
            nxt_o.coil      = coil_of(cur_i.phase);
            nxt_o.hold      = '0;
          end
        end
      end
    end else if (word_i.req == ReqTick && cur_i.mode != MODE_IDLE && !speed_err) begin
      nxt_o.hold = hold_inc;
      if (hold_inc >= delay_i) begin
        nxt_o.phase     = adv_phase;
        nxt_o.pos_step  = adv_step;
        nxt_o.pos_lap   = adv_lap;
        nxt_o.remaining = rem_dec;
        if (rem_dec != '0) begin
          nxt_o.coil = coil_of(adv_phase);
          nxt_o.hold = '0;
        end else if (cur_i.mode == MODE_GOTO && end_plan.go) begin
          nxt_o.remaining = end_plan.remaining;
          nxt_o.dir       = end_plan.dir;
          nxt_o.coil      = coil_of(adv_phase);
          nxt_o.hold      = '0;
        end else begin
          nxt_o.mode = MODE_IDLE;
          nxt_o.hold = '0;
        end
      end
    end
  end

endmodule
